// ===== design/mpu_pkg.sv =====
// Package for the multiset prefix unrank core: field widths, register
// indexes, defaults, controller state and controller/datapath handshake types.
// No dependencies.
`default_nettype none

package mpu_pkg;

   localparam int IDX_W              = 11;
   localparam int NUM_VALUES_W       = 11;
   localparam int DEPTH_W            = 3;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 11;
   localparam int LVL_W              = 2;

   localparam int DEFAULT_MAX_VALUES = 1024;
   localparam int DEFAULT_RANK_BITS  = 40;

   localparam logic [NUM_VALUES_W-1:0] NUM_VALUES_RESET = 11'd1024;
   localparam logic [DEPTH_W-1:0]      DEPTH_RESET      = 3'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_VALUES   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_DEPTH = 1'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RAMP,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             load;
      logic             ramp;
      logic             step;
      logic             record;
      logic             finish_ok;
      logic             fail;
      logic             publish;
      logic [LVL_W-1:0] lvl;
      logic [1:0]       slots;
   } cmd_type;

   typedef struct packed {
      logic ramp_done;
      logic exhausted;
      logic hit;
   } status_type;

endpackage

`default_nettype wire

// ===== design/mpu_datapath.sv =====
// Datapath of the multiset prefix unrank core: rank remainder, candidate
// value, running repeated-combination counts, index registers, output register.
// Depends on mpu_pkg.
`default_nettype none

module mpu_datapath
   import mpu_pkg::*;
#(
   parameter int MaxValues = DEFAULT_MAX_VALUES,
   parameter int RankBits  = DEFAULT_RANK_BITS
) (
   input  wire logic                    clock,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   input  wire logic [NUM_VALUES_W-1:0] num_values,
   input  wire logic [RankBits-1:0]     req_rank,
   output logic                         rsp_found,
   output logic signed [IDX_W-1:0]      rsp_first_index,
   output logic signed [IDX_W-1:0]      rsp_second_index,
   output logic signed [IDX_W-1:0]      rsp_third_index,
   output logic signed [IDX_W-1:0]      rsp_fourth_index
);

   localparam int VAL_BITS = $clog2(MaxValues + 1);
   localparam int CNT_BITS = 3 * VAL_BITS;
   localparam int CMP_BITS = (RankBits > CNT_BITS) ? RankBits : CNT_BITS;

   logic [RankBits-1:0] r_ff, r_in;
   logic [VAL_BITS-1:0] v_ff, v_in;
   logic [VAL_BITS-1:0] a_ff, a_in;
   logic [CNT_BITS-1:0] c2_ff, c2_in;
   logic [CNT_BITS-1:0] c3_ff, c3_in;
   logic [IDX_W-1:0]    idx_ff [4];
   logic [IDX_W-1:0]    idx_in [4];
   logic                found_ff, found_in;

   logic                rsp_found_ff;
   logic [IDX_W-1:0]    rsp_idx_ff [4];

   logic [VAL_BITS-1:0] n_eff;
   logic [CNT_BITS-1:0] v_ext;
   logic [CNT_BITS-1:0] c_sel;
   logic [LVL_W-1:0]    lvl_next;

   always_comb begin
      if (int'(num_values) > MaxValues) begin
         n_eff = VAL_BITS'(MaxValues);
      end else begin
         n_eff = VAL_BITS'(num_values);
      end
   end

   assign v_ext    = CNT_BITS'(v_ff);
   assign lvl_next = cmd.lvl + LVL_W'(1);

   // count of completions for the current candidate at this level
   always_comb begin
      case (cmd.slots)
         2'd3:    c_sel = c3_ff;
         2'd2:    c_sel = c2_ff;
         default: c_sel = v_ext;
      endcase
   end

   assign status.ramp_done = (v_ff == n_eff);
   assign status.exhausted = (v_ff == '0);
   assign status.hit       = (CMP_BITS'(r_ff) < CMP_BITS'(c_sel));

   always_comb begin
      r_in     = r_ff;
      v_in     = v_ff;
      a_in     = a_ff;
      c2_in    = c2_ff;
      c3_in    = c3_ff;
      idx_in   = idx_ff;
      found_in = found_ff;

      if (cmd.load) begin
         r_in     = req_rank;
         v_in     = '0;
         a_in     = '0;
         c2_in    = '0;
         c3_in    = '0;
         found_in = 1'b0;
         for (int k = 0; k < 4; k++) begin
            idx_in[k] = {IDX_W{1'b1}};
         end
      end

      // build up v(v+1)/2 and v(v+1)(v+2)/6 while v climbs to min(num_values, MaxValues)
      if (cmd.ramp) begin
         v_in  = v_ff + VAL_BITS'(1);
         c2_in = c2_ff + v_ext + CNT_BITS'(1);
         c3_in = c3_ff + c2_ff + v_ext + CNT_BITS'(1);
      end

      // drop the candidate's completions and move to the next value
      if (cmd.step) begin
         r_in  = RankBits'(CMP_BITS'(r_ff) - CMP_BITS'(c_sel));
         a_in  = a_ff + VAL_BITS'(1);
         v_in  = v_ff - VAL_BITS'(1);
         c3_in = c3_ff - c2_ff;
         c2_in = c2_ff - v_ext;
      end

      if (cmd.record) begin
         idx_in[cmd.lvl] = IDX_W'(a_ff);
      end

      if (cmd.finish_ok) begin
         idx_in[lvl_next] = IDX_W'(a_ff + VAL_BITS'(r_ff));
         found_in         = 1'b1;
      end

      if (cmd.fail) begin
         found_in = 1'b0;
         for (int k = 0; k < 4; k++) begin
            idx_in[k] = {IDX_W{1'b1}};
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      v_ff     <= v_in;
      a_ff     <= a_in;
      c2_ff    <= c2_in;
      c3_ff    <= c3_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      if (cmd.publish) begin
         rsp_found_ff <= found_ff;
         rsp_idx_ff   <= idx_ff;
      end
   end

   assign rsp_found        = rsp_found_ff;
   assign rsp_first_index  = signed'(rsp_idx_ff[0]);
   assign rsp_second_index = signed'(rsp_idx_ff[1]);
   assign rsp_third_index  = signed'(rsp_idx_ff[2]);
   assign rsp_fourth_index = signed'(rsp_idx_ff[3]);

endmodule

`default_nettype wire

// ===== design/mpu_ctrl.sv =====
// Controller of the multiset prefix unrank core: sequences ramp, level scan
// and result hand-off, and owns the input stall and the output valid.
// Depends on mpu_pkg.
`default_nettype none

module mpu_ctrl
   import mpu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [DEPTH_W-1:0] prefix_depth,
   input  wire status_type         status,
   output cmd_type                 cmd
);

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             depth_ok;
   logic [LVL_W-1:0] last_lvl;

   assign depth_ok = (prefix_depth inside {[3'd2:3'd4]});
   assign last_lvl = LVL_W'(prefix_depth - 3'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      cmd       = '0;
      cmd.lvl   = lvl_ff;
      cmd.slots = 2'(prefix_depth - 3'd1 - {1'b0, lvl_ff});
      req_stall = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               lvl_in   = '0;
               state_in = depth_ok ? ST_RAMP : ST_FINISH;
            end
         end
         ST_RAMP: begin
            if (status.ramp_done) begin
               state_in = ST_SCAN;
            end else begin
               cmd.ramp = 1'b1;
            end
         end
         ST_SCAN: begin
            if (status.exhausted) begin
               cmd.fail = 1'b1;
               state_in = ST_FINISH;
            end else if (status.hit) begin
               cmd.record = 1'b1;
               if (lvl_ff == last_lvl) begin
                  cmd.finish_ok = 1'b1;
                  state_in      = ST_FINISH;
               end else begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/multiset_prefix_unrank_core.sv =====
// Multiset prefix unrank core, top level: configuration registers, controller
// and datapath. After accept, the controller builds the counts while the
// candidate value climbs to n = min(num_values, MAX_VALUES), scans the levels
// and hands off the result; an unsupported depth goes straight to hand-off.
// A new request is taken only after the previous one is handed off; a new
// one is taken while a result waits on stall. Synchronous reset restores 1024, 2.
`default_nettype none

module multiset_prefix_unrank_core
   import mpu_pkg::*;
#(
   parameter int MAX_VALUES = DEFAULT_MAX_VALUES,
   parameter int RANK_BITS  = DEFAULT_RANK_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [RANK_BITS-1:0]   req_rank,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic signed [IDX_W-1:0]     rsp_first_index,
   output logic signed [IDX_W-1:0]     rsp_second_index,
   output logic signed [IDX_W-1:0]     rsp_third_index,
   output logic signed [IDX_W-1:0]     rsp_fourth_index
);

   logic [NUM_VALUES_W-1:0] num_values_ff;
   logic [DEPTH_W-1:0]      prefix_depth_ff;
   cmd_type                 cmd;
   status_type              status;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_values_ff   <= NUM_VALUES_RESET;
         prefix_depth_ff <= DEPTH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NUM_VALUES:   num_values_ff   <= csr_wdata[NUM_VALUES_W-1:0];
            CSR_PREFIX_DEPTH: prefix_depth_ff <= csr_wdata[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mpu_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .prefix_depth (prefix_depth_ff),
      .status       (status),
      .cmd          (cmd)
   );

   mpu_datapath #(
      .MaxValues (MAX_VALUES),
      .RankBits  (RANK_BITS)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .num_values       (num_values_ff),
      .req_rank         (req_rank),
      .rsp_found        (rsp_found),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .rsp_third_index  (rsp_third_index),
      .rsp_fourth_index (rsp_fourth_index)
   );

endmodule

`default_nettype wire

// ===== verif/multiset_prefix_unrank_core_test.sv =====
// Self-checking testbench for multiset_prefix_unrank_core: drives ranks under
// several num_values / prefix_depth settings and checks every returned tuple.
// Depends on mpu_pkg and the multiset_prefix_unrank_core RTL only.
`timescale 1ns / 1ps

module multiset_prefix_unrank_core_test
   import mpu_pkg::*;
;

   localparam int RANK_W     = DEFAULT_RANK_BITS;
   localparam int VALUES_CAP = DEFAULT_MAX_VALUES;
   localparam int RANDOM_RANKS = 170;

   typedef struct packed {
      logic                      found;
      logic [3:0][IDX_W-1:0]     index;   // index[0] is the first slot
   } tuple_type;

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = CSR_NUM_VALUES;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [RANK_W-1:0]        req_rank  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_found;
   logic signed [IDX_W-1:0]  rsp_first_index;
   logic signed [IDX_W-1:0]  rsp_second_index;
   logic signed [IDX_W-1:0]  rsp_third_index;
   logic signed [IDX_W-1:0]  rsp_fourth_index;

   multiset_prefix_unrank_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rank         (req_rank),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_first_index  (rsp_first_index),
      .rsp_second_index (rsp_second_index),
      .rsp_third_index  (rsp_third_index),
      .rsp_fourth_index (rsp_fourth_index)
   );

   class unrank_scoreboard;
      logic [NUM_VALUES_W-1:0] num_values;
      logic [DEPTH_W-1:0]      prefix_depth;
      tuple_type               expected_tuples[$];
      int unsigned             mismatches;

      function new();
         num_values   = NUM_VALUES_RESET;
         prefix_depth = DEPTH_RESET;
         mismatches   = 0;
      endfunction

      function void apply_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_NUM_VALUES) begin
            num_values = data[NUM_VALUES_W-1:0];
         end else if (index == CSR_PREFIX_DEPTH) begin
            prefix_depth = data[DEPTH_W-1:0];
         end
      endfunction

      // number of non-decreasing tuples of the given length over v values
      function longint unsigned multiset_size(longint unsigned v, int slots);
         longint unsigned c;
         c = 1;
         for (int i = 0; i < slots; i++) begin
            c = c * (v + i) / (i + 1);
         end
         return c;
      endfunction

      function longint unsigned clamped_values();
         return (num_values > VALUES_CAP) ? VALUES_CAP : num_values;
      endfunction

      function bit depth_supported();
         return prefix_depth >= 2 && prefix_depth <= 4;
      endfunction

      function longint unsigned tuple_count();
         if (!depth_supported()) begin
            return 0;
         end
         return multiset_size(clamped_values(), prefix_depth);
      endfunction

      function tuple_type unrank(logic [RANK_W-1:0] rank);
         tuple_type       t;
         longint unsigned r;
         longint unsigned n;
         longint unsigned lo;
         longint unsigned a;
         int              depth;
         bit              ok;
         r     = rank;
         n     = clamped_values();
         depth = prefix_depth;
         ok    = depth_supported();
         lo    = 0;
         t.found = 1'b0;
         t.index = '1;
         for (int lvl = 0; ok && lvl + 1 < depth; lvl++) begin
            a = lo;
            // skip whole blocks of completions until the rank lands in one
            while (a < n && r >= multiset_size(n - a, depth - 1 - lvl)) begin
               r -= multiset_size(n - a, depth - 1 - lvl);
               a++;
            end
            if (a >= n) begin
               ok = 1'b0;
            end else begin
               t.index[lvl] = a[IDX_W-1:0];
               lo = a;
            end
         end
         if (ok) begin
            t.found = 1'b1;
            t.index[depth-1] = IDX_W'(lo + r);
         end else begin
            t.index = '1;
         end
         return t;
      endfunction

      function void note_request(logic [RANK_W-1:0] rank);
         expected_tuples.push_back(unrank(rank));
      endfunction

      function void check_response(logic found, logic [3:0][IDX_W-1:0] index);
         tuple_type exp;
         if (expected_tuples.size() == 0) begin
            $display("%0t: unexpected transaction: found %0b, indexes %h", $time, found, index);
            mismatches++;
            return;
         end
         exp = expected_tuples.pop_front();
         if (exp.found !== found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, exp.found, found);
            mismatches++;
         end
         for (int k = 0; k < 4; k++) begin
            if (exp.index[k] !== index[k]) begin
               $display("%0t: slot %0d index mismatch: expected %0d, actual %0d",
                        $time, k, $signed(exp.index[k]), $signed(index[k]));
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_tuples.size();
      endfunction
   endclass

   unrank_scoreboard  sb;
   logic [RANK_W-1:0] rank_queue[$];
   int                stall_mode = 0;
   int                stall_hold = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("multiset_prefix_unrank_core regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_rank);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_found, {rsp_fourth_index, rsp_third_index,
                                       rsp_second_index, rsp_first_index});
      end
   end

   // receiver back-pressure: switch between a few stall patterns at random
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_hold <= $urandom_range(16, 80);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_hold % 6 != 0);
      endcase
   end

   task automatic send_ranks();
      int burst_left;
      burst_left = $urandom_range(1, 5);
      while (rank_queue.size() != 0) begin
         @(negedge clock);
         req_valid <= 1'b1;
         req_rank  <= rank_queue.pop_front();
         do @(posedge clock); while (req_stall !== 1'b0);
         burst_left--;
         if (burst_left == 0 || rank_queue.size() == 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 5);
         end
      end
   endtask

   // sampled on falling edges so the posedge monitors have already run
   task automatic wait_idle();
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.apply_csr(index, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] values, logic [CSR_DATA_W-1:0] depth_word);
      wait_idle();
      write_csr(CSR_NUM_VALUES, values);
      write_csr(CSR_PREFIX_DEPTH, depth_word);
   endtask

   // first, last and one-past-last rank of the current setting
   task automatic queue_ends();
      longint unsigned total;
      total = sb.tuple_count();
      rank_queue.push_back('0);
      rank_queue.push_back(RANK_W'(total - 1));
      rank_queue.push_back(RANK_W'(total));
   endtask

   function automatic logic [RANK_W-1:0] pick_rank(longint unsigned total);
      longint unsigned wide;
      wide = {$urandom, $urandom};
      if (total == 0) begin
         return wide[RANK_W-1:0];
      end
      case ($urandom_range(0, 11))
         0: return wide[RANK_W-1:0];
         1: return RANK_W'(total + $urandom_range(0, 3));
         2: return RANK_W'(total - 1);
         3: return '0;
         default: return RANK_W'(wide % total);
      endcase
   endfunction

   initial begin
      int              unsupported[5] = '{0, 1, 5, 6, 7};
      int              random_sent;
      int              count;
      bit              wide_set;
      logic [CSR_DATA_W-1:0] values;
      logic [CSR_DATA_W-1:0] depth_word;

      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: 1024 values, pairs
      queue_ends();
      rank_queue.push_back('1);
      send_ranks();

      // single value; upper data bits set on the depth write
      configure(11'd1, 11'h7FA);
      rank_queue.push_back('0);
      rank_queue.push_back(RANK_W'(1));
      send_ranks();

      // no values at all
      configure(11'd0, 11'd3);
      rank_queue.push_back('0);
      send_ranks();

      // num_values above the cap, deepest tuples
      configure(11'h7FF, 11'd4);
      queue_ends();
      send_ranks();

      foreach (unsupported[i]) begin
         configure(11'd5, CSR_DATA_W'(unsupported[i]));
         rank_queue.push_back(RANK_W'(3));
         send_ranks();
      end

      configure(11'd4, 11'd3);
      queue_ends();
      rank_queue.push_back(RANK_W'(7));
      send_ranks();

      configure(11'd1024, 11'd3);
      rank_queue.push_back(RANK_W'(sb.tuple_count() - 1));
      send_ranks();

      // random settings; wide value counts are slow, so keep them short
      random_sent = 0;
      while (random_sent < RANDOM_RANKS) begin
         wide_set = 1'b0;
         case ($urandom_range(0, 15))
            0: values = '0;
            1: begin
               values   = CSR_DATA_W'($urandom_range(1000, 2047));
               wide_set = 1'b1;
            end
            default: values = CSR_DATA_W'($urandom_range(1, 48));
         endcase
         if ($urandom_range(0, 9) == 0) begin
            depth_word = CSR_DATA_W'($urandom_range(0, 2047));
         end else begin
            depth_word = {CSR_DATA_W'($urandom_range(0, 255)) << DEPTH_W}
                         | CSR_DATA_W'($urandom_range(2, 4));
         end
         configure(values, depth_word);
         count = wide_set ? $urandom_range(1, 3) : $urandom_range(4, 12);
         for (int i = 0; i < count; i++) begin
            rank_queue.push_back(pick_rank(sb.tuple_count()));
         end
         send_ranks();
         random_sent += count;
      end

      wait_idle();
      repeat (2 * VALUES_CAP + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("multiset_prefix_unrank_core regression: pass");
      end else begin
         $display("multiset_prefix_unrank_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mpu_pkg.sv
design/mpu_datapath.sv
design/mpu_ctrl.sv
design/multiset_prefix_unrank_core.sv
verif/multiset_prefix_unrank_core_test.sv
